// File: rtl/ita_pkg.sv
// ita_pkg: shared constants, format descriptor type and digit-to-ASCII
// mapping for the integer-to-ASCII formatter. No dependencies.
package ita_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int RUN_MAX        = 64;
	localparam int CNT_W          = 8;

	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_OCT = 2'd1;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_A_UP  = 8'h41;

	typedef struct packed {
		logic       upper;
		logic       left;
		logic       zpad;
		logic       alt;
		logic       plus;
		logic       blank;
		logic       sgn;
		logic       neg;
		logic       hex;
		logic       oct;
		logic [5:0] width;
		logic [5:0] prec;
	} fmt_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] r;
		if (d < 4'd10)
			r = CH_ZERO + {4'd0, d};
		else
			r = (upper ? CH_A_UP : CH_A_LO) + {4'd0, d} - 8'd10;
		return r;
	endfunction

endpackage

// File: rtl/integer_to_ascii_formatter_unit.sv
// integer_to_ascii_formatter_unit: printf-style integer to ASCII text, one char word per cycle.
// Decimal runs the bit-serial shift/add-3 digit unit, then the digit align scan; octal/hex
// go straight to the align scan. A plan step follows, then the char words.
// A new start is taken only when not busy; busy drops after the last char.
// Reset: arst_n clears busy, the FSM states and strobe/last; no char words appear until a start is taken.
// Depends on ita_pkg, ita_conv, ita_emit.
module integer_to_ascii_formatter_unit #(
	parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic [1:0]                   base_sel,
	input  logic                         is_signed,
	input  logic                         upper_case,
	input  logic                         left_align,
	input  logic                         zero_pad,
	input  logic                         alt_form,
	input  logic                         plus_sign,
	input  logic                         blank_sign,
	input  logic [5:0]                   width,
	input  logic [5:0]                   precision,
	output logic                         strobe,
	output logic [7:0]                   out_char,
	output logic                         last
);

	localparam int DIG_N  = (VALUE_BITS + 2) / 3;
	localparam int NDIG_W = $clog2(DIG_N + 1);

	logic                  busy_q;
	ita_pkg::fmt_t         fmt_q;
	logic                  accept, neg, hex, oct;
	logic [VALUE_BITS-1:0] uval, mag;
	logic                  conv_done, emit_done;
	logic [4*DIG_N-1:0]    digits;
	logic [NDIG_W-1:0]     ndig;

	assign accept = start && !busy_q;
	assign uval   = VALUE_BITS'(value);
	assign neg    = is_signed && uval[VALUE_BITS-1];
	assign mag    = neg ? (~uval + 1'b1) : uval;
	assign hex    = base_sel[1];
	assign oct    = (base_sel == ita_pkg::BASE_OCT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			if (accept)
				busy_q <= 1'b1;
			else if (emit_done)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fmt_q.upper <= upper_case;
			fmt_q.left  <= left_align;
			fmt_q.zpad  <= zero_pad;
			fmt_q.alt   <= alt_form;
			fmt_q.plus  <= plus_sign;
			fmt_q.blank <= blank_sign;
			fmt_q.sgn   <= is_signed;
			fmt_q.neg   <= neg;
			fmt_q.hex   <= hex;
			fmt_q.oct   <= oct;
			fmt_q.width <= width;
			fmt_q.prec  <= precision;
		end
	end

	ita_conv #(.VALUE_BITS(VALUE_BITS)) u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.hex    (hex),
		.oct    (oct),
		.done   (conv_done),
		.digits (digits),
		.ndig   (ndig)
	);

	ita_emit #(.VALUE_BITS(VALUE_BITS)) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (conv_done),
		.fmt      (fmt_q),
		.digits   (digits),
		.ndig     (ndig),
		.done     (emit_done),
		.strobe   (strobe),
		.out_char (out_char),
		.last     (last)
	);

	assign busy = busy_q;

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy_q) else $error("char word outside a run");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q) else $error("busy not raised after start");
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe) else $error("last without strobe");
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe) else $error("char word right after last");
	a_conv_idle: assert property (@(posedge clk) disable iff (!arst_n)
		conv_done |-> busy_q && !strobe) else $error("digits ready during a run");

endmodule

// File: rtl/ita_conv.sv
// ita_conv: turns the unsigned magnitude into a digit register, MS digit on top,
// plus the digit count. Decimal runs a shift/add-3 unit one bit per cycle.
// Depends on ita_pkg.
module ita_conv #(
	parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF,
	localparam int DIG_N  = (VALUE_BITS + 2) / 3,
	localparam int NDIG_W = $clog2(DIG_N + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_BITS-1:0]  mag,
	input  logic                   hex,
	input  logic                   oct,
	output logic                   done,
	output logic [4*DIG_N-1:0]     digits,
	output logic [NDIG_W-1:0]      ndig
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_DAB   = 2'd1;
	localparam logic [1:0] S_ALIGN = 2'd2;
	localparam int BIT_W = $clog2(VALUE_BITS + 1);

	logic [1:0]            state_q;
	logic [4*DIG_N-1:0]    bcd_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic [BIT_W-1:0]      bit_q;
	logic [NDIG_W-1:0]     ndig_q;
	logic                  done_q;

	logic [4*DIG_N-1:0] hex_nib;
	logic [3*DIG_N-1:0] ext3;
	logic [4*DIG_N-1:0] oct_nib;
	logic [4*DIG_N-1:0] adj;

	assign hex_nib = (4*DIG_N)'(mag);
	assign ext3    = (3*DIG_N)'(mag);

	for (genvar i = 0; i < DIG_N; i++) begin : g_nib
		assign oct_nib[4*i +: 4] = {1'b0, ext3[3*i +: 3]};
		assign adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
			bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						ndig_q <= NDIG_W'(DIG_N);
						if (hex) begin
							bcd_q   <= hex_nib;
							state_q <= S_ALIGN;
						end else if (oct) begin
							bcd_q   <= oct_nib;
							state_q <= S_ALIGN;
						end else begin
							bcd_q   <= '0;
							mag_q   <= mag;
							bit_q   <= BIT_W'(VALUE_BITS);
							state_q <= S_DAB;
						end
					end
				end
				S_DAB: begin
					bcd_q <= {adj[4*DIG_N-2:0], mag_q[VALUE_BITS-1]};
					mag_q <= mag_q << 1;
					bit_q <= bit_q - 1'b1;
					if (bit_q == BIT_W'(1))
						state_q <= S_ALIGN;
				end
				S_ALIGN: begin
					if (bcd_q[4*DIG_N-1 -: 4] == 4'd0 && ndig_q > NDIG_W'(1)) begin
						bcd_q  <= bcd_q << 4;
						ndig_q <= ndig_q - 1'b1;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign digits = bcd_q;
	assign ndig   = ndig_q;

endmodule

// File: rtl/ita_emit.sv
// ita_emit: plans the segment bounds (sign, prefix, zeros, digits, spaces)
// and sends one character word per cycle. Depends on ita_pkg.
module ita_emit #(
	parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF,
	localparam int DIG_N  = (VALUE_BITS + 2) / 3,
	localparam int NDIG_W = $clog2(DIG_N + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  ita_pkg::fmt_t        fmt,
	input  logic [4*DIG_N-1:0]   digits,
	input  logic [NDIG_W-1:0]    ndig,
	output logic                 done,
	output logic                 strobe,
	output logic [7:0]           out_char,
	output logic                 last
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PLAN = 2'd1;
	localparam logic [1:0] S_RUN  = 2'd2;
	localparam int W = ita_pkg::CNT_W;

	logic [1:0]          state_q;
	ita_pkg::fmt_t       fmt_q;
	logic [4*DIG_N-1:0]  dig_q;
	logic [NDIG_W-1:0]   nd_q;
	logic [W-1:0]        b1_q, b2_q, b3_q, b4_q, b5_q, pos_q;
	logic                strobe_q, last_q;
	logic [7:0]          char_q;

	logic              sign_n;
	logic [1:0]        pfx_n;
	logic signed [8:0] lead, rest, nd9, zeros, pzr, zc, sp;
	logic [7:0]        ch;
	logic              in_dig, last_c;

	always_comb begin
		sign_n = fmt_q.sgn && (fmt_q.neg || fmt_q.plus || fmt_q.blank);
		pfx_n  = (fmt_q.alt && fmt_q.hex) ? 2'd2 : ((fmt_q.alt && fmt_q.oct) ? 2'd1 : 2'd0);
		lead   = signed'(9'(sign_n)) + signed'(9'(pfx_n));
		nd9    = signed'(9'(nd_q));
		rest   = signed'(9'(fmt_q.width)) - lead - nd9;
		zeros  = (fmt_q.zpad && !fmt_q.left && rest > 0) ? rest : 9'sd0;
		pzr    = signed'(9'(fmt_q.prec)) - zeros - nd9;
		zc     = zeros + ((pzr > 0) ? pzr : 9'sd0);
		sp     = (fmt_q.left && rest > 0) ? rest : 9'sd0;
	end

	always_comb begin
		in_dig = 1'b0;
		if (pos_q < b1_q)
			ch = fmt_q.neg ? ita_pkg::CH_MINUS :
				(fmt_q.plus ? ita_pkg::CH_PLUS : ita_pkg::CH_SPACE);
		else if (pos_q < b2_q)
			ch = (pos_q == b1_q) ? ita_pkg::CH_ZERO :
				(fmt_q.upper ? ita_pkg::CH_X_UP : ita_pkg::CH_X_LO);
		else if (pos_q < b3_q)
			ch = ita_pkg::CH_ZERO;
		else if (pos_q < b4_q) begin
			ch     = ita_pkg::digit_char(dig_q[4*DIG_N-1 -: 4], fmt_q.upper);
			in_dig = 1'b1;
		end else
			ch = ita_pkg::CH_SPACE;
		last_c = (pos_q == b5_q - 1'b1) || (pos_q == W'(ita_pkg::RUN_MAX - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						fmt_q   <= fmt;
						dig_q   <= digits;
						nd_q    <= ndig;
						state_q <= S_PLAN;
					end
				end
				S_PLAN: begin
					b1_q    <= W'(sign_n);
					b2_q    <= W'(sign_n) + W'(pfx_n);
					b3_q    <= W'(sign_n) + W'(pfx_n) + zc[W-1:0];
					b4_q    <= W'(lead + zc + nd9);
					b5_q    <= W'(lead + zc + nd9 + sp);
					pos_q   <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					strobe_q <= 1'b1;
					char_q   <= ch;
					last_q   <= last_c;
					pos_q    <= pos_q + 1'b1;
					if (in_dig)
						dig_q <= dig_q << 4;
					if (last_c)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done     = strobe_q && last_q;
	assign strobe   = strobe_q;
	assign out_char = char_q;
	assign last     = last_q;

endmodule
